// ===== rtl/skq_pkg.sv =====
package skq_pkg;

    localparam int MAX_SIDE = 32;
    localparam int VAL_W    = 30;
    localparam int POS_W    = 6;
    localparam int RANK_W   = 11;
    // rectangle holds at most 32 x 32 cells, as its bounds are clamped to MAX_SIDE
    localparam int CNT_W    = 12;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

endpackage

// ===== rtl/skq_store.sv =====
module skq_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [skq_pkg::VAL_W-1:0]   i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    input  logic                        i_clear,
    input  logic [skq_pkg::VAL_W-1:0]   i_limit,
    output logic [skq_pkg::CNT_W-1:0]   o_count
);
    import skq_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [CNT_W-1:0] r_count;
    logic [VAL_W-1:0] cell_eff;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // stored values below one count as one
    assign cell_eff = (r_rd_data == '0) ? VAL_W'(1) : r_rd_data;
    assign hit      = r_rd_vld && (cell_eff <= i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_rd_vld <= i_rd_en;
            if (i_clear) begin
                r_count <= '0;
            end else if (hit) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_count = r_count;

endmodule

// ===== rtl/submatrix_kth_smallest.sv =====
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------------------
// request  | in        | start & !busy             | i_cmd, i_row_lo, i_col_lo, i_row_hi,
//          |           |                           | i_col_hi, i_cell_value, i_rank
// result   | out       | o_valid, one cycle        | o_answer
// config   | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (side_length)
//
// a load request is written at the accepting edge and never raises busy
// a query runs a binary search over the value range, about log2(VALUE_MAX)
// steps (30 for the default); each step reads the rectangle cells from the
// cell memory one per cycle through the memory's single read port
// reset is synchronous, active low; the cell memory is not cleared
// the result strobe cannot be held off by the receiver
module submatrix_kth_smallest #(
    parameter int VALUE_MAX = 1000000000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [skq_pkg::POS_W-1:0]   i_row_lo,
    input  logic [skq_pkg::POS_W-1:0]   i_col_lo,
    input  logic [skq_pkg::POS_W-1:0]   i_row_hi,
    input  logic [skq_pkg::POS_W-1:0]   i_col_hi,
    input  logic [skq_pkg::VAL_W-1:0]   i_cell_value,
    input  logic [skq_pkg::RANK_W-1:0]  i_rank,
    output logic                        o_valid,
    output logic [skq_pkg::VAL_W-1:0]   o_answer,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [skq_pkg::POS_W-1:0]   i_cfg_data
);
    import skq_pkg::*;

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // state and registers
    t_state           r_state, n_state;
    logic [POS_W-1:0] r_side;
    logic [POS_W-1:0] r_r0, n_r0, r_r1, n_r1, r_c0, n_c0, r_c1, n_c1;
    logic             r_empty, n_empty;
    logic [RANK_W-1:0] r_k, n_k;
    logic [VAL_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [POS_W-1:0] r_row, n_row, r_col, n_col;
    logic             r_out_vld, n_out_vld;
    logic [VAL_W-1:0] r_answer, n_answer;

    // side in use, saturated to the memory size
    logic [POS_W-1:0] side_eff;
    logic             req_acc;
    logic             load_ok;
    logic [POS_W-1:0] q_r0, q_c0, q_r1, q_c1;
    logic [POS_W-1:0] ld_row_m1, ld_col_m1, sc_row_m1, sc_col_m1;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic             wr_en, rd_en, cnt_clear;
    logic [CNT_W-1:0] count;

    assign side_eff = (int'(r_side) > MAX_SIDE) ? POS_W'(MAX_SIDE) : r_side;
    assign busy     = (r_state != S_IDLE);
    assign req_acc  = start && !busy;

    // config port
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= POS_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_side <= i_cfg_data;
        end
    end

    // load path: written at the accepting edge
    assign load_ok = (i_row_lo != '0) && (i_row_lo <= side_eff)
                  && (i_col_lo != '0) && (i_col_lo <= side_eff);
    assign wr_en     = req_acc && (i_cmd == CMD_LOAD) && load_ok;
    assign ld_row_m1 = i_row_lo - POS_W'(1);
    assign ld_col_m1 = i_col_lo - POS_W'(1);
    assign wr_addr   = ADDR_W'(int'(ld_row_m1) * MAX_SIDE + int'(ld_col_m1));

    // scan address from the 1-based row and column counters
    assign sc_row_m1 = r_row - POS_W'(1);
    assign sc_col_m1 = r_col - POS_W'(1);
    assign rd_addr   = ADDR_W'(int'(sc_row_m1) * MAX_SIDE + int'(sc_col_m1));

    // query bounds clamped into the matrix
    assign q_r0 = (i_row_lo == '0) ? POS_W'(1) : i_row_lo;
    assign q_c0 = (i_col_lo == '0) ? POS_W'(1) : i_col_lo;
    assign q_r1 = (i_row_hi > side_eff) ? side_eff : i_row_hi;
    assign q_c1 = (i_col_hi > side_eff) ? side_eff : i_col_hi;

    skq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cell_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_clear   (cnt_clear),
        .i_limit   (r_mid),
        .o_count   (count)
    );

    // binary search sequencer
    always_comb begin
        n_state   = r_state;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_c0      = r_c0;
        n_c1      = r_c1;
        n_empty   = r_empty;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_row     = r_row;
        n_col     = r_col;
        n_out_vld = 1'b0;
        n_answer  = r_answer;
        rd_en     = 1'b0;
        cnt_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && (i_cmd == CMD_QUERY)) begin
                    n_r0    = q_r0;
                    n_c0    = q_c0;
                    n_r1    = q_r1;
                    n_c1    = q_c1;
                    n_empty = (q_r0 > q_r1) || (q_c0 > q_c1);
                    n_k     = i_rank;
                    n_lo    = VAL_W'(1);
                    n_hi    = VAL_W'(VALUE_MAX);
                    n_state = S_MID;
                end
            end
            S_MID: begin
                if (r_lo < r_hi) begin
                    n_mid     = r_lo + ((r_hi - r_lo) >> 1);
                    cnt_clear = 1'b1;
                    n_row     = r_r0;
                    n_col     = r_c0;
                    // an empty rectangle counts zero without a scan
                    n_state   = r_empty ? S_DECIDE : S_SCAN;
                end else begin
                    n_out_vld = 1'b1;
                    n_answer  = r_lo;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                if (r_col == r_c1) begin
                    n_col = r_c0;
                    if (r_row == r_r1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_row = r_row + POS_W'(1);
                    end
                end else begin
                    n_col = r_col + POS_W'(1);
                end
            end
            S_DRAIN: begin
                // last read lands in the count this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (count >= CNT_W'(r_k)) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + VAL_W'(1);
                end
                n_state = S_MID;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_empty  <= n_empty;
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_row    <= n_row;
        r_col    <= n_col;
        r_answer <= n_answer;
    end

    assign o_valid  = r_out_vld;
    assign o_answer = r_answer;

endmodule
